// ===== src/fefm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fefm_pkg
// Types and constants shared by the filtered edge frequency meter.
// ----------------------------------------------------------------------------
package fefm_pkg;

	localparam int CAP_W   = 16;              // capture timestamp
	localparam int GAP_W   = 15;              // masked interval
	localparam int MAX_W   = 16;              // max_interval register
	localparam int CLK_W   = 25;              // clock_hz register
	localparam int EDGE_W  = 24;              // edge counter
	localparam int TICK_W  = 6;               // tick counter
	localparam int FREQ_W  = 16;              // visible part of frequency
	localparam int SCALE_W = CLK_W + 1 - 16;  // (clock_hz + bias) >> 16
	localparam int NUM_W   = EDGE_W + SCALE_W; // dividend width
	localparam int CNT_W   = $clog2(NUM_W + 1);
	localparam int IDX_W   = 2;
	localparam int CFG_W   = CLK_W;

	localparam logic [GAP_W-1:0]  MIN_RESET     = '0;
	localparam logic [MAX_W-1:0]  MAX_RESET     = MAX_W'(32768);
	localparam logic [CLK_W-1:0]  CLK_RESET     = CLK_W'(1000000);
	localparam logic [NUM_W-1:0]  PRODUCT_LIMIT = NUM_W'(2000);
	localparam logic [EDGE_W-1:0] EDGE_LIMIT    = EDGE_W'(24'h800000);
	localparam logic [EDGE_W-1:0] EDGE_MAX      = {EDGE_W{1'b1}};
	localparam logic [TICK_W-1:0] TICK_LIMIT    = TICK_W'(40);
	localparam logic [CLK_W:0]    CLOCK_BIAS    = (CLK_W+1)'(256);

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_MIN_INTERVAL = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_MAX_INTERVAL = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_CLOCK_HZ     = IDX_W'(2);

	// input kinds carried on tuser
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_TICK,
		ST_PROD,
		ST_NUM,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

endpackage

// ===== src/filtered_edge_frequency_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_edge_frequency_meter
// Edge counter with interval window and iterative frequency divider.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: s_tuser selects the kind (0 captured edge, 1 period tick),
//   s_tdata holds the 16-bit capture timestamp. Master stream: m_tdata is the
//   low 16 bits of the held frequency, m_tuser flags an edge that passed the
//   interval window. One result transaction per input transaction.
//   The cfg channel writes min_interval (0), max_interval (1), clock_hz (2);
//   cfg_ready is always high, other indexes are ignored.
//   An edge passes ST_EDGE and ST_EMIT before m_tvalid is registered. A tick
//   that computes a new frequency passes ST_TICK, ST_PROD, ST_NUM, ST_DIV and
//   ST_FIN: one shared multiplier forms edges*ticks and then scale*edges, and
//   a radix-2 restoring divider forms the quotient, one bit a cycle. Other
//   ticks skip ST_NUM and ST_DIV. One item is in work at a time; s_tready is
//   low meanwhile. A finished result sits in the output register while the
//   next item is taken; when the receiver stalls and that register is full,
//   the block holds the new result and stays busy until m_tready frees it.
//   Reset clears all counters and frequencies and loads register defaults.
// ----------------------------------------------------------------------------
module filtered_edge_frequency_meter (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fefm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [fefm_pkg::CFG_W-1:0]    cfg_data,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fefm_pkg::CAP_W-1:0]    s_tdata,   // [15:0] capture_value
	input  logic                          s_tuser,   // [0] cmd
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fefm_pkg::FREQ_W-1:0]   m_tdata,   // [15:0] shadow_frequency
	output logic                          m_tuser    // [0] edge_accepted
);
	import fefm_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [GAP_W-1:0]  min_q;
	logic [MAX_W-1:0]  max_q;
	logic [CLK_W-1:0]  clock_q;

	// measurement state
	logic [CAP_W-1:0]  last_q;
	logic [EDGE_W-1:0] edge_q;
	logic [TICK_W-1:0] tick_q;
	logic [FREQ_W-1:0] run_q;
	logic [FREQ_W-1:0] held_q;
	logic              acc_q;
	logic              div_q;

	// work registers
	logic [CAP_W-1:0]  cap_q;
	logic [NUM_W-1:0]  num_q;
	logic [TICK_W-1:0] rem_q;
	logic [FREQ_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;

	// output register
	logic              m_tvalid_q;
	logic [FREQ_W-1:0] m_tdata_q;
	logic              m_tuser_q;

	logic [CAP_W-1:0]  diff;
	logic [GAP_W-1:0]  gap;
	logic              gap_ok;
	logic [CLK_W:0]    clk_bias;
	logic [SCALE_W-1:0] scale;
	logic [SCALE_W-1:0] mul_b;
	logic [NUM_W-1:0]  mul_p;
	logic [TICK_W:0]   trial;
	logic [TICK_W:0]   trial_sub;
	logic              trial_ge;
	logic              out_free;
	logic              restart;
	logic [FREQ_W-1:0] run_new;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign out_free  = !m_tvalid_q || m_tready;

	// interval window
	assign diff   = cap_q - last_q;
	assign gap    = diff[GAP_W-1:0];
	assign gap_ok = (gap > min_q) && ({1'b0, gap} < max_q);

	// shared multiplier: edges * ticks, then scale * edges
	assign clk_bias = {1'b0, clock_q} + CLOCK_BIAS;
	assign scale    = clk_bias[CLK_W:16];
	assign mul_b    = (state_q == ST_PROD) ? SCALE_W'(tick_q) : scale;
	assign mul_p    = NUM_W'(edge_q) * NUM_W'(mul_b);

	// one restoring divide step
	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, tick_q};
	assign trial_ge  = (trial >= {1'b0, tick_q});

	assign restart = (edge_q > EDGE_LIMIT) || (tick_q > TICK_LIMIT);
	assign run_new = div_q ? quo_q : run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == CMD_TICK) ? ST_TICK : ST_EDGE;
				end
			end
			ST_EDGE: state_d = ST_EMIT;
			ST_TICK: state_d = ST_PROD;
			ST_PROD: state_d = (mul_p > PRODUCT_LIMIT) ? ST_NUM : ST_FIN;
			ST_NUM:  state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= MIN_RESET;
			max_q   <= MAX_RESET;
			clock_q <= CLK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_INTERVAL: min_q   <= cfg_data[GAP_W-1:0];
				REG_MAX_INTERVAL: max_q   <= cfg_data[MAX_W-1:0];
				REG_CLOCK_HZ:     clock_q <= cfg_data[CLK_W-1:0];
				default: ;
			endcase
		end
	end

	// measurement state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			edge_q     <= '0;
			tick_q     <= '0;
			run_q      <= '0;
			held_q     <= '0;
			acc_q      <= 1'b0;
			div_q      <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					acc_q <= 1'b0;
					div_q <= 1'b0;
				end
				ST_EDGE: begin
					acc_q <= gap_ok;
					if (gap_ok) begin
						last_q <= cap_q;
						if (edge_q != EDGE_MAX) begin
							edge_q <= edge_q + EDGE_W'(1);
						end
					end
				end
				ST_TICK: tick_q <= tick_q + TICK_W'(1);
				ST_PROD: div_q <= (mul_p > PRODUCT_LIMIT);
				ST_NUM:  cnt_q <= '0;
				ST_DIV:  cnt_q <= cnt_q + CNT_W'(1);
				ST_FIN: begin
					if (restart) begin
						held_q <= run_new;
						run_q  <= '0;
						edge_q <= '0;
						tick_q <= '0;
					end else begin
						run_q <= run_new;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cap_q <= s_tdata;
				end
			end
			ST_NUM: begin
				num_q <= mul_p + NUM_W'(tick_q >> 1);
				rem_q <= '0;
				quo_q <= '0;
			end
			ST_DIV: begin
				num_q <= {num_q[NUM_W-2:0], 1'b0};
				rem_q <= trial_ge ? trial_sub[TICK_W-1:0] : trial[TICK_W-1:0];
				quo_q <= {quo_q[FREQ_W-2:0], trial_ge};
			end
			ST_EMIT: begin
				if (out_free) begin
					m_tdata_q <= held_q;
					m_tuser_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while block did not go busy");

	a_tick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= TICK_LIMIT + TICK_W'(1))
		else $error("tick count beyond restart limit");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> tick_q != '0 && rem_q < tick_q)
		else $error("divider remainder out of range");

	a_emit_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !out_free |=> state_q == ST_EMIT && m_tvalid_q)
		else $error("result dropped while output register full");

	a_edge_no_tick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EDGE |=> $stable(tick_q))
		else $error("edge item changed tick count");
`endif

endmodule
